// ===== src/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk and quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define HST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define HST_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== src/hst_pkg.sv =====
package hst_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_BITS  = 4;
    localparam int VALUE_BITS = 32;
    localparam int FUNC_BITS  = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_PUT    = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_GET    = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd2;

    localparam int IN_BITS  = FUNC_BITS + SLOT_BITS + VALUE_BITS;
    localparam int OUT_BITS = 1 + SLOT_BITS + VALUE_BITS;
    localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic load;
        logic exec;
        logic out_load;
    } hst_cmd_t;

    typedef struct packed {
        logic out_valid;
    } hst_status_t;

endpackage

// ===== src/hst_datapath.sv =====
`include "assert_macros.svh"

module hst_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hst_pkg::hst_cmd_t               cmd,
    output hst_pkg::hst_status_t            status,
    input  logic [hst_pkg::FUNC_BITS-1:0]   func,
    input  logic [hst_pkg::SLOT_BITS-1:0]   slot_in,
    input  logic [hst_pkg::VALUE_BITS-1:0]  value_in,
    input  logic                            m_tready,
    output logic                            ok,
    output logic [hst_pkg::SLOT_BITS-1:0]   slot_out,
    output logic [hst_pkg::VALUE_BITS-1:0]  value_out
);
    import hst_pkg::*;

    logic [FUNC_BITS-1:0]  func_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [SLOTS-1:0]      occ_reg;
    logic [SLOTS-1:0]      occ_next;
    logic [VALUE_BITS-1:0] mem [SLOTS];
    logic [VALUE_BITS-1:0] rdata_reg;
    logic                  res_ok_reg;
    logic [SLOT_BITS-1:0]  res_slot_reg;
    logic                  res_rd_reg;
    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic [SLOT_BITS-1:0]  out_slot_reg;
    logic [VALUE_BITS-1:0] out_value_reg;

    logic                  free_found;
    logic [SLOT_BITS-1:0]  free_idx;
    logic                  in_range;
    logic                  hit;
    logic                  is_put;
    logic                  is_lookup;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_BITS'(i);
            end
        end
    end

    assign in_range  = ({1'b0, slot_reg} < (SLOT_BITS + 1)'(SLOTS));
    assign hit       = in_range && occ_reg[slot_reg];
    assign is_put    = (func_reg == FUNC_PUT);
    assign is_lookup = (func_reg == FUNC_GET) || (func_reg == FUNC_REMOVE);

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.exec)
        begin
            if (is_put && free_found)
            begin
                occ_next[free_idx] = 1'b1;
            end
            else if ((func_reg == FUNC_REMOVE) && hit)
            begin
                occ_next[slot_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && is_put && free_found)
        begin
            mem[free_idx] <= value_reg;
        end
        if (cmd.exec)
        begin
            rdata_reg <= mem[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            slot_reg  <= slot_in;
            value_reg <= value_in;
        end
        if (cmd.exec)
        begin
            res_ok_reg   <= (is_put && free_found) || (is_lookup && hit);
            res_slot_reg <= (is_put && free_found) ? free_idx : '0;
            res_rd_reg   <= is_lookup && hit;
        end
        if (cmd.out_load)
        begin
            out_ok_reg    <= res_ok_reg;
            out_slot_reg  <= res_slot_reg;
            out_value_reg <= res_rd_reg ? rdata_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_valid = out_valid_reg;
    assign ok        = out_ok_reg;
    assign slot_out  = out_slot_reg;
    assign value_out = out_value_reg;

    `HST_ASSERT_NEXT(a_occ_only_in_exec, !cmd.exec, $stable(occ_reg),
        "occupancy changed outside the table access step")
    `HST_ASSERT_NEXT(a_put_claims_one, cmd.exec && is_put && free_found,
        $countones(occ_reg) == $countones($past(occ_reg)) + 1,
        "successful put did not claim exactly one slot")

endmodule

// ===== src/hst_ctrl.sv =====
`include "assert_macros.svh"

module hst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  m_tready,
    input  hst_pkg::hst_status_t  status,
    output hst_pkg::hst_cmd_t     cmd
);
    import hst_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_free;

    assign out_free = !status.out_valid || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `HST_ASSERT_NEXT(a_exec_then_result, state_reg == ST_EXEC, state_reg == ST_RESULT,
        "table access not followed by result step")
    `HST_ASSERT(a_no_overwrite, !cmd.out_load || out_free,
        "result loaded over a pending transaction")
    `HST_ASSERT_NEXT(a_load_then_exec, cmd.load, cmd.exec,
        "accepted request not executed next cycle")

endmodule

// ===== src/handle_slot_table_unit.sv =====
// Handle slot table: 16 slots of 32-bit values with an occupancy bitmap that
// clears at reset. A put claims the lowest free slot and returns its index
// (ok low when full); get returns the stored value of an occupied slot;
// remove frees an occupied slot and returns its old value. The controller
// steps each request through capture, table access (free-slot priority
// encoder plus one write or registered read of the value RAM) and result
// load, and m_tvalid rises when the result load fills the result register. The
// next request is accepted while a result still waits on the master side, but
// not before the current request has passed all three controller steps. An
// earlier result still held on the master side delays the result load, and so
// the next acceptance.
module handle_slot_table_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // func[1:0], slot_in[5:2], value_in[37:6], zero pad above
    input  logic [hst_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // ok[0], slot_out[4:1], value_out[36:5], zero pad above
    output logic [hst_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);
    import hst_pkg::*;

    hst_cmd_t              cmd;
    hst_status_t           status;
    logic                  ok;
    logic [SLOT_BITS-1:0]  slot_out;
    logic [VALUE_BITS-1:0] value_out;

    hst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hst_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .func      (s_tdata[FUNC_BITS-1:0]),
        .slot_in   (s_tdata[FUNC_BITS +: SLOT_BITS]),
        .value_in  (s_tdata[FUNC_BITS + SLOT_BITS +: VALUE_BITS]),
        .m_tready  (m_tready),
        .ok        (ok),
        .slot_out  (slot_out),
        .value_out (value_out)
    );

    assign m_tvalid = status.out_valid;
    assign m_tdata  = {{(OUT_TDATA_BITS - OUT_BITS){1'b0}}, value_out, slot_out, ok};

endmodule

// ===== tb/sv/slot_table_checker.sv =====
`timescale 1ns / 1ps

module slot_table_checker
    import hst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [OUT_TDATA_BITS-1:0] m_tdata,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic                  ok;
        logic [SLOT_BITS-1:0]  slot;
        logic [VALUE_BITS-1:0] value;
    } reply_t;

    logic [SLOTS-1:0]      slot_taken;
    logic [VALUE_BITS-1:0] slot_value [SLOTS];
    reply_t                reply_q [$];
    reply_t                want;
    reply_t                got;
    int                    misses;

    function automatic reply_t serve_request(input logic [FUNC_BITS-1:0]  op,
                                             input logic [SLOT_BITS-1:0]  slot,
                                             input logic [VALUE_BITS-1:0] value);
        reply_t r;
        r = '0;
        case (op)
            FUNC_PUT:
                for (int k = 0; k < SLOTS; k++) begin
                    if (!slot_taken[k] && !r.ok) begin
                        slot_taken[k] = 1'b1;
                        slot_value[k] = value;
                        r.ok          = 1'b1;
                        r.slot        = SLOT_BITS'(k);
                    end
                end
            FUNC_GET, FUNC_REMOVE:
                if (int'(slot) < SLOTS && slot_taken[slot]) begin
                    r.ok    = 1'b1;
                    r.value = slot_value[slot];
                    if (op == FUNC_REMOVE) begin
                        slot_taken[slot] = 1'b0;
                        slot_value[slot] = '0;
                    end
                end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_BITS-1:0] expected,
                               input logic [VALUE_BITS-1:0] actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
            misses++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            slot_taken = '0;
            reply_q.delete();
            misses = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            // retire the oldest expectation before queuing a new one
            if (m_tvalid && m_tready) begin
                got.ok    = m_tdata[0];
                got.slot  = m_tdata[SLOT_BITS:1];
                got.value = m_tdata[OUT_BITS-1:SLOT_BITS+1];
                if (reply_q.size() == 0) begin
                    $error("unexpected transaction: ok %0h slot_out %0h value_out %0h",
                           got.ok, got.slot, got.value);
                    misses++;
                end
                else begin
                    want = reply_q.pop_front();
                    check_field("ok", VALUE_BITS'(want.ok), VALUE_BITS'(got.ok));
                    check_field("slot_out", VALUE_BITS'(want.slot), VALUE_BITS'(got.slot));
                    check_field("value_out", want.value, got.value);
                end
            end
            if (s_tvalid && s_tready) begin
                reply_q.push_back(serve_request(
                    s_tdata[FUNC_BITS-1:0],
                    s_tdata[FUNC_BITS+SLOT_BITS-1:FUNC_BITS],
                    s_tdata[IN_BITS-1:FUNC_BITS+SLOT_BITS]));
            end
            fail_count <= misses;
            pending    <= reply_q.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import hst_pkg::*;

    localparam logic [FUNC_BITS-1:0] FUNC_NOP = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 13;
    localparam int PHASE_LEN   = 150;
    localparam int DRAIN_PHASE = 5;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    int wait_max = 12;
    int quiet    = 0;
    int fail_count;
    int pending;

    handle_slot_table_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    slot_table_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever begin
            #5 clk = ~clk;
        end
    end

    task automatic issue(input logic [FUNC_BITS-1:0]  op,
                         input logic [SLOT_BITS-1:0]  slot,
                         input logic [VALUE_BITS-1:0] value);
        int gap;
        gap = $urandom_range(0, wait_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_BITS-IN_BITS){1'b0}}, value, slot, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // result side: stall a random number of cycles before each transaction
    initial begin
        int stall;
        forever begin
            stall = $urandom_range(0, wait_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial begin
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int                   put_pct;
        int                   roll;
        logic [FUNC_BITS-1:0] op;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unused code, then fill every slot, overflow, and free and reuse a slot
        issue(FUNC_GET, 4'd0, 32'hFFFF_FFFF);
        issue(FUNC_REMOVE, 4'd15, 32'h0);
        issue(FUNC_NOP, 4'd15, 32'hFFFF_FFFF);
        issue(FUNC_PUT, 4'd15, 32'h0000_0000);
        issue(FUNC_PUT, 4'd0, 32'hFFFF_FFFF);
        for (int k = 2; k < SLOTS; k++) begin
            issue(FUNC_PUT, SLOT_BITS'(k), (k % 2 != 0) ? 32'hA5A5_A5A5 : 32'h5A5A_5A5A);
        end
        issue(FUNC_PUT, 4'd0, 32'hDEAD_BEEF);
        issue(FUNC_GET, 4'd1, 32'h0);
        issue(FUNC_REMOVE, 4'd0, 32'h0);
        issue(FUNC_GET, 4'd0, 32'h0);
        issue(FUNC_PUT, 4'd9, 32'h1234_5678);
        issue(FUNC_REMOVE, 4'd15, 32'hFFFF_FFFF);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0:       put_pct = 70;
                1:       put_pct = 25;
                2:       put_pct = 50;
                default: put_pct = 90;
            endcase
            wait_max = (phase % 3 == 2) ? 0 : 12;
            for (int i = 0; i < PHASE_LEN; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    op = FUNC_NOP;
                else if (roll < 4 + put_pct * 96 / 100)
                    op = FUNC_PUT;
                else
                    op = ($urandom_range(0, 1) != 0) ? FUNC_GET : FUNC_REMOVE;
                issue(op, SLOT_BITS'($urandom_range(0, SLOTS - 1)), pick_value());
            end
            if (phase == DRAIN_PHASE)
                drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
